/* src/etd_pkg.sv */
// Shared types, constants and opcodes for the extended delay timer.
package etd_pkg;

    // Default counter width and the fixed widths of the overflow, divider, tick and APB fields.
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int OVF_WIDTH       = 16;
    localparam int DIV_WIDTH       = 32;
    localparam int DIVISOR_WIDTH   = 7;
    localparam int TICK_WIDTH      = 6;
    localparam int APB_ADDR_WIDTH  = 4;
    localparam int APB_DATA_WIDTH  = 32;

    // Opcodes carried in the input item.
    localparam logic [2:0] OP_PULSE       = 3'd0;
    localparam logic [2:0] OP_START_TIMER = 3'd1;
    localparam logic [2:0] OP_START_COUNT = 3'd2;
    localparam logic [2:0] OP_WRITE_COUNT = 3'd3;
    localparam logic [2:0] OP_READ_COUNT  = 3'd4;
    localparam logic [2:0] OP_STOP        = 3'd5;

    // Configuration register indexes (word address bits).
    localparam logic [1:0] REG_PRESCALE = 2'd0;
    localparam logic [1:0] REG_OSC_MHZ  = 2'd1;
    localparam logic [1:0] REG_MODE     = 2'd2;
    localparam logic [1:0] REG_EVENT    = 2'd3;

    // Reset value of the oscillator frequency.
    localparam logic [DIVISOR_WIDTH-1:0] OSC_MHZ_RESET = 7'd4;

    // Instruction cycles per prescaled tick before the prescaler divides.
    localparam logic [DIV_WIDTH-1:0] TICK_BASE = 32'd4;

    // Milliseconds to microseconds.
    localparam logic [9:0] MS_TO_US = 10'd1000;

    // Counter writes store the value plus this bias.
    localparam int WRITE_BIAS = 2;

    // Configuration register set.
    typedef struct packed {
        logic [1:0]               prescale_log;
        logic [DIVISOR_WIDTH-1:0] osc_mhz;
        logic                     counter_mode;
        logic                     event_enable;
    } cfg_t;

    // Request to the shared divider.
    typedef struct packed {
        logic                     start;
        logic [DIV_WIDTH-1:0]     dividend;
        logic [DIVISOR_WIDTH-1:0] divisor;
    } div_req_t;

    // Response from the shared divider.
    typedef struct packed {
        logic                 done;
        logic [DIV_WIDTH-1:0] quotient;
    } div_rsp_t;

endpackage

/* src/etd_cfg.sv */
// Configuration register bank behind the APB-style port.
module etd_cfg
    import etd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_WIDTH-1:0] paddr,
    input  logic [APB_DATA_WIDTH-1:0] pwdata,
    output logic [APB_DATA_WIDTH-1:0] prdata,
    output logic                      pready,
    output cfg_t                      cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_index;
    logic       wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite && pready;
    assign cfg       = cfg_reg;

    // Register write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_index)
                REG_PRESCALE: cfg_next.prescale_log = pwdata[1:0];
                REG_OSC_MHZ:  cfg_next.osc_mhz      = pwdata[DIVISOR_WIDTH-1:0];
                REG_MODE:     cfg_next.counter_mode = pwdata[0];
                REG_EVENT:    cfg_next.event_enable = pwdata[0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    // Register read mux.
    always_comb
    begin
        case (reg_index)
            REG_PRESCALE: prdata = 32'(cfg_reg.prescale_log);
            REG_OSC_MHZ:  prdata = 32'(cfg_reg.osc_mhz);
            REG_MODE:     prdata = 32'(cfg_reg.counter_mode);
            REG_EVENT:    prdata = 32'(cfg_reg.event_enable);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prescale_log <= '0;
            cfg_reg.osc_mhz      <= OSC_MHZ_RESET;
            cfg_reg.counter_mode <= 1'b0;
            cfg_reg.event_enable <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* src/etd_div.sv */
// Shared restoring divider: one quotient bit per cycle.
module etd_div
    import etd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_WIDTH = $clog2(DIV_WIDTH);

    logic                     busy_reg;
    logic                     busy_next;
    logic                     done_reg;
    logic                     done_next;
    logic [CNT_WIDTH-1:0]     cnt_reg;
    logic [CNT_WIDTH-1:0]     cnt_next;
    logic [DIV_WIDTH-1:0]     quo_reg;
    logic [DIV_WIDTH-1:0]     quo_next;
    logic [DIVISOR_WIDTH-1:0] rem_reg;
    logic [DIVISOR_WIDTH-1:0] rem_next;
    logic [DIVISOR_WIDTH-1:0] dsr_reg;
    logic [DIVISOR_WIDTH-1:0] dsr_next;
    logic [DIVISOR_WIDTH:0]   rem_shift;
    logic [DIVISOR_WIDTH+1:0] diff;

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    // Shift the next dividend bit into the remainder and try a subtract.
    assign rem_shift = {rem_reg, quo_reg[DIV_WIDTH-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (busy_reg)
        begin
            if (!diff[DIVISOR_WIDTH+1])
            begin
                rem_next = diff[DIVISOR_WIDTH-1:0];
                quo_next = {quo_reg[DIV_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[DIVISOR_WIDTH-1:0];
                quo_next = {quo_reg[DIV_WIDTH-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_WIDTH'(DIV_WIDTH - 1);
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            dsr_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            dsr_reg  <= dsr_next;
        end
    end

endmodule

/* src/extended_delay_timer.sv */
// Top level of the extended delay timer: sequencer, counter state and stream ports.
//
// A prescaled up-counter with overflow extension. Every input item gives exactly one
// result item. Source pulses, counter writes and reads, start counter and stop are
// handled in the cycle they are taken. Start timer, when its settings are valid,
// runs two passes of one shared 32-step restoring divider (first the tick time, then
// the tick count), and the block takes no new item until the result is loaded. An
// error on start timer (wrong mode, zero or too high oscillator setting) returns at
// once. The output register lets a new item be taken in the cycle its result is taken.
module extended_delay_timer
    import etd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // Input item: opcode [2:0], delay [25:3], counter_value [41:26].
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [47:0]               s_tdata,
    // Result item: status [0], read_data [16:1], overflow [17], expired [18].
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [23:0]               m_tdata,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_WIDTH-1:0] paddr,
    input  logic [APB_DATA_WIDTH-1:0] pwdata,
    output logic [APB_DATA_WIDTH-1:0] prdata,
    output logic                      pready
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_TICK  = 2'd1;
    localparam logic [1:0] ST_TICKS = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    cfg_t     cfg;
    div_req_t div_req;
    div_rsp_t div_rsp;

    // Input item fields.
    logic [2:0]  opcode;
    logic [22:0] delay_val;
    logic [15:0] counter_value;

    assign opcode        = s_tdata[2:0];
    assign delay_val     = s_tdata[25:3];
    assign counter_value = s_tdata[41:26];

    // Control and counter state.
    logic [1:0]             state_reg, state_next;
    logic                   running_reg, running_next;
    logic [2:0]             presc_reg, presc_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [OVF_WIDTH-1:0]   ovf_cnt_reg, ovf_cnt_next;
    logic [OVF_WIDTH-1:0]   target_reg, target_next;
    logic [COUNT_WIDTH-1:0] reload_reg, reload_next;
    logic [DIV_WIDTH-1:0]   prod_reg, prod_next;
    logic [DIV_WIDTH-1:0]   ticks_reg, ticks_next;

    // Output register.
    logic        m_valid_reg, m_valid_next;
    logic        status_reg, status_next;
    logic [15:0] rdata_reg, rdata_next;
    logic        ovf_reg, ovf_next;
    logic        exp_reg, exp_next;

    logic                   accept;
    logic                   out_free;
    logic [3:0]             presc_inc;
    logic [3:0]             presc_lim;
    logic [DIV_WIDTH-1:0]   tick_num;
    logic                   start_err;
    logic [32:0]            prod_full;
    logic [31:0]            cval_wide;
    logic [31:0]            count_wide;
    logic [DIV_WIDTH-1:0]   ticks_hi;
    logic [COUNT_WIDTH-1:0] reload_calc;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, exp_reg, ovf_reg, rdata_reg, status_reg};

    etd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    etd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Prescaler step and limit.
    assign presc_inc = {1'b0, presc_reg} + 4'd1;
    assign presc_lim = 4'd1 << cfg.prescale_log;

    // Start timer setup: tick numerator and the error check (mode, zero or too high oscillator).
    assign tick_num  = TICK_BASE << cfg.prescale_log;
    assign start_err = cfg.counter_mode || (cfg.osc_mhz == '0)
                       || (cfg.osc_mhz > tick_num[DIVISOR_WIDTH-1:0]);
    assign prod_full = 33'(delay_val) * 33'(MS_TO_US);

    // Width adaptation of the written value and the read value.
    assign cval_wide  = {16'b0, counter_value};
    assign count_wide = 32'(count_reg);

    // Split of the tick count into overflows and preload.
    assign ticks_hi    = ticks_reg >> COUNT_WIDTH;
    assign reload_calc = '0 - ticks_reg[COUNT_WIDTH-1:0];

    // Sequencer and item handling.
    always_comb
    begin
        state_next   = state_reg;
        running_next = running_reg;
        presc_next   = presc_reg;
        count_next   = count_reg;
        ovf_cnt_next = ovf_cnt_reg;
        target_next  = target_reg;
        reload_next  = reload_reg;
        prod_next    = prod_reg;
        ticks_next   = ticks_reg;
        m_valid_next = m_valid_reg && !m_tready;
        status_next  = status_reg;
        rdata_next   = rdata_reg;
        ovf_next     = ovf_reg;
        exp_next     = exp_reg;
        div_req      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    m_valid_next = 1'b1;
                    status_next  = 1'b0;
                    rdata_next   = '0;
                    ovf_next     = 1'b0;
                    exp_next     = 1'b0;
                    case (opcode)
                        OP_PULSE:
                        begin
                            if (running_reg)
                            begin
                                if (presc_inc >= presc_lim)
                                begin
                                    presc_next = '0;
                                    count_next = count_reg + COUNT_WIDTH'(1);
                                    if (count_reg == '1)
                                    begin
                                        ovf_next = 1'b1;
                                        if (cfg.event_enable)
                                        begin
                                            if (ovf_cnt_reg == target_reg)
                                            begin
                                                count_next = reload_reg
                                                             + COUNT_WIDTH'(WRITE_BIAS);
                                                ovf_cnt_next = '0;
                                                exp_next     = 1'b1;
                                            end
                                            else
                                            begin
                                                ovf_cnt_next = ovf_cnt_reg + 1'b1;
                                            end
                                        end
                                    end
                                end
                                else
                                begin
                                    presc_next = presc_inc[2:0];
                                end
                            end
                        end
                        OP_START_TIMER:
                        begin
                            if (start_err)
                            begin
                                status_next = 1'b1;
                            end
                            else
                            begin
                                // Hold the result until the divider passes finish.
                                m_valid_next     = 1'b0;
                                prod_next        = prod_full[DIV_WIDTH-1:0];
                                div_req.start    = 1'b1;
                                div_req.dividend = tick_num;
                                div_req.divisor  = cfg.osc_mhz;
                                state_next       = ST_TICK;
                            end
                        end
                        OP_START_COUNT:
                        begin
                            if (!cfg.counter_mode)
                            begin
                                status_next = 1'b1;
                            end
                            else
                            begin
                                running_next = 1'b1;
                            end
                        end
                        OP_WRITE_COUNT:
                        begin
                            count_next = cval_wide[COUNT_WIDTH-1:0]
                                         + COUNT_WIDTH'(WRITE_BIAS);
                        end
                        OP_READ_COUNT:
                        begin
                            rdata_next = count_wide[15:0];
                        end
                        OP_STOP:
                        begin
                            running_next = 1'b0;
                        end
                        default:
                        begin
                            status_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_TICK:
            begin
                // Tick time known: divide the microsecond count by it.
                if (div_rsp.done)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = prod_reg;
                    div_req.divisor  = {1'b0, div_rsp.quotient[TICK_WIDTH-1:0]};
                    state_next       = ST_TICKS;
                end
            end
            ST_TICKS:
            begin
                if (div_rsp.done)
                begin
                    ticks_next = div_rsp.quotient;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Commit the new timing and return a plain ok result.
                if (out_free)
                begin
                    target_next  = ticks_hi[OVF_WIDTH-1:0];
                    reload_next  = reload_calc;
                    count_next   = reload_calc + COUNT_WIDTH'(WRITE_BIAS);
                    running_next = 1'b1;
                    m_valid_next = 1'b1;
                    status_next  = 1'b0;
                    rdata_next   = '0;
                    ovf_next     = 1'b0;
                    exp_next     = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            running_reg <= 1'b0;
            presc_reg   <= '0;
            count_reg   <= '0;
            ovf_cnt_reg <= '0;
            target_reg  <= '0;
            reload_reg  <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            running_reg <= running_next;
            presc_reg   <= presc_next;
            count_reg   <= count_next;
            ovf_cnt_reg <= ovf_cnt_next;
            target_reg  <= target_next;
            reload_reg  <= reload_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        ticks_reg  <= ticks_next;
        status_reg <= status_next;
        rdata_reg  <= rdata_next;
        ovf_reg    <= ovf_next;
        exp_reg    <= exp_next;
    end

endmodule
